// File: rtl/ffpa_pkg.sv
`default_nettype none
package ffpa_pkg;

  localparam int unsigned ADDR_W   = 52;
  localparam int unsigned LEN_W    = 25;
  localparam int unsigned STATUS_W = 2;

  // Request opcodes
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_SPACE   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_TABLE_FULL = 2'd2;

  // Configuration register indexes
  localparam logic CFG_BASE_PAGE = 1'b0;
  localparam logic CFG_PAGES     = 1'b1;

  typedef struct packed {
    logic [ADDR_W-1:0] base_page;
    logic [LEN_W-1:0]  length;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_MOVE,
    S_MISS,
    S_OUT
  } state_t;

endpackage
`default_nettype wire

// File: rtl/ffpa_ram.sv
`default_nettype none
module ffpa_ram #(
  parameter int unsigned WIDTH = 77,
  parameter int unsigned DEPTH = 128,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: rtl/first_fit_page_range_allocator.sv
// Flow: a request scans the table from entry 0 until an entry fits; an exact fit adds a
//   move step that pulls the last entry into its slot, and a request that misses every
//   entry takes the miss step. The result then waits in S_OUT for the output register.
// Throughput: one request at a time; the single-port read of the range table, one entry
//   per cycle, sets the scan length. The next request is taken while the result waits.
// Reset: synchronous, active low; clears range count, tail offset, region registers and
//   handshake state. The range table is not cleared; only entries below the count are read.
`default_nettype none
module first_fit_page_range_allocator
  import ffpa_pkg::*;
#(
  parameter int unsigned MAX_RANGES = 128
) (
  input  wire logic                clk,
  input  wire logic                rst_n,

  input  wire logic                cfg_we,
  input  wire logic                cfg_index,
  input  wire logic [ADDR_W-1:0]   cfg_wdata,

  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic                in_operation,
  input  wire logic [LEN_W-1:0]    in_page_count,
  input  wire logic [ADDR_W-1:0]   in_free_page,

  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic      [STATUS_W-1:0] out_status,
  output logic      [ADDR_W-1:0]   out_alloc_page
);

  localparam int unsigned IDX_W = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_RANGES + 1);

  // Control state
  state_t             state_r, state_nxt;
  logic [IDX_W-1:0]   scan_idx_r, scan_idx_nxt;
  logic [CNT_W-1:0]   range_count_r, range_count_nxt;
  logic [LEN_W-1:0]   next_offset_r, next_offset_nxt;
  logic [ADDR_W-1:0]  base_page_r, base_page_nxt;
  logic [LEN_W-1:0]   region_pages_r, region_pages_nxt;
  logic               out_valid_r, out_valid_nxt;

  // Request and result payload
  logic               op_r, op_nxt;
  logic [LEN_W-1:0]   cnt_r, cnt_nxt;
  logic [ADDR_W-1:0]  fpage_r, fpage_nxt;
  logic [ADDR_W-1:0]  fend_r, fend_nxt;
  logic [STATUS_W-1:0] res_status_r, res_status_nxt;
  logic [ADDR_W-1:0]  res_page_r, res_page_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [ADDR_W-1:0]  out_page_r, out_page_nxt;

  // Range table port
  logic               mem_we;
  logic [IDX_W-1:0]   mem_waddr;
  entry_t             mem_wdata;
  logic [IDX_W-1:0]   mem_raddr;
  entry_t             rd_entry;

  logic [IDX_W-1:0]   last_idx;
  logic               table_full;
  logic [LEN_W:0]     tail_end;

  ffpa_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (MAX_RANGES),
    .AW    (IDX_W)
  ) u_table (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (rd_entry)
  );

  assign last_idx   = IDX_W'(range_count_r - 1'b1);
  assign table_full = (range_count_r == CNT_W'(MAX_RANGES));
  assign tail_end   = {1'b0, next_offset_r} + {1'b0, cnt_r};

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_alloc_page = out_page_r;

  always_comb begin
    state_nxt        = state_r;
    scan_idx_nxt     = scan_idx_r;
    range_count_nxt  = range_count_r;
    next_offset_nxt  = next_offset_r;
    base_page_nxt    = base_page_r;
    region_pages_nxt = region_pages_r;
    out_valid_nxt    = out_valid_r;
    op_nxt           = op_r;
    cnt_nxt          = cnt_r;
    fpage_nxt        = fpage_r;
    fend_nxt         = fend_r;
    res_status_nxt   = res_status_r;
    res_page_nxt     = res_page_r;
    out_status_nxt   = out_status_r;
    out_page_nxt     = out_page_r;

    in_ready  = (state_r == S_IDLE);
    // Prefetch the entry after the one under test
    mem_raddr = scan_idx_r + 1'b1;
    mem_we    = 1'b0;
    mem_waddr = scan_idx_r;
    mem_wdata = rd_entry;

    // The user must write configuration only while idle; the block does not enforce this
    if (cfg_we) begin
      case (cfg_index)
        CFG_BASE_PAGE: base_page_nxt    = cfg_wdata;
        CFG_PAGES:     region_pages_nxt = cfg_wdata[LEN_W-1:0];
        default:       ;
      endcase
    end

    // Drop the result beat once taken
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt       = in_operation;
          cnt_nxt      = in_page_count;
          fpage_nxt    = in_free_page;
          fend_nxt     = in_free_page + ADDR_W'(in_page_count);
          scan_idx_nxt = '0;
          mem_raddr    = '0;
          state_nxt    = (range_count_r == '0) ? S_MISS : S_SCAN;
        end
      end

      // rd_entry holds the entry at scan_idx_r
      S_SCAN: begin
        if (op_r == OP_ALLOC) begin
          if (rd_entry.length >= cnt_r) begin
            res_status_nxt = ST_OK;
            res_page_nxt   = rd_entry.base_page;
            if (rd_entry.length > cnt_r) begin
              // Split: shrink the entry from the bottom
              mem_we              = 1'b1;
              mem_wdata.base_page = rd_entry.base_page + ADDR_W'(cnt_r);
              mem_wdata.length    = rd_entry.length - cnt_r;
              state_nxt           = S_OUT;
            end else begin
              // Exact fit: fetch the last entry to fill the hole
              mem_raddr = last_idx;
              state_nxt = S_MOVE;
            end
          end else if (scan_idx_r == last_idx) begin
            state_nxt = S_MISS;
          end else begin
            scan_idx_nxt = scan_idx_r + 1'b1;
          end
        end else begin
          res_page_nxt = '0;
          if (rd_entry.base_page + ADDR_W'(rd_entry.length) == fpage_r) begin
            // Entry ends where the freed range starts
            mem_we           = 1'b1;
            mem_wdata.length = rd_entry.length + cnt_r;
            res_status_nxt   = ST_OK;
            state_nxt        = S_OUT;
          end else if (fend_r == rd_entry.base_page) begin
            // Freed range ends where the entry starts
            mem_we              = 1'b1;
            mem_wdata.base_page = fpage_r;
            mem_wdata.length    = rd_entry.length + cnt_r;
            res_status_nxt      = ST_OK;
            state_nxt           = S_OUT;
          end else if (scan_idx_r == last_idx) begin
            state_nxt = S_MISS;
          end else begin
            scan_idx_nxt = scan_idx_r + 1'b1;
          end
        end
      end

      // rd_entry now holds the last entry; move it into the taken slot
      S_MOVE: begin
        mem_we          = 1'b1;
        mem_waddr       = scan_idx_r;
        mem_wdata       = rd_entry;
        range_count_nxt = range_count_r - 1'b1;
        state_nxt       = S_OUT;
      end

      S_MISS: begin
        if (op_r == OP_ALLOC) begin
          if (tail_end > {1'b0, region_pages_r}) begin
            // Out of space: leave the tail pointer where it is
            res_status_nxt = ST_NO_SPACE;
            res_page_nxt   = '0;
          end else begin
            res_status_nxt  = ST_OK;
            res_page_nxt    = base_page_r + ADDR_W'(next_offset_r);
            next_offset_nxt = tail_end[LEN_W-1:0];
          end
        end else begin
          res_page_nxt = '0;
          if (table_full) begin
            res_status_nxt = ST_TABLE_FULL;
          end else begin
            // Append a new entry at the end of the table
            mem_we              = 1'b1;
            mem_waddr           = range_count_r[IDX_W-1:0];
            mem_wdata.base_page = fpage_r;
            mem_wdata.length    = cnt_r;
            range_count_nxt     = range_count_r + 1'b1;
            res_status_nxt      = ST_OK;
          end
        end
        state_nxt = S_OUT;
      end

      // Hold the result until the output register is free
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_page_nxt   = res_page_r;
          state_nxt      = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      scan_idx_r     <= '0;
      range_count_r  <= '0;
      next_offset_r  <= '0;
      base_page_r    <= '0;
      region_pages_r <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      scan_idx_r     <= scan_idx_nxt;
      range_count_r  <= range_count_nxt;
      next_offset_r  <= next_offset_nxt;
      base_page_r    <= base_page_nxt;
      region_pages_r <= region_pages_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    cnt_r        <= cnt_nxt;
    fpage_r      <= fpage_nxt;
    fend_r       <= fend_nxt;
    res_status_r <= res_status_nxt;
    res_page_r   <= res_page_nxt;
    out_status_r <= out_status_nxt;
    out_page_r   <= out_page_nxt;
  end

  // The table never holds more entries than it has slots
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    range_count_r <= CNT_W'(MAX_RANGES))
    else $error("range count exceeds table depth");

  // A failed request never reports a page
  a_fail_page_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_status_r != ST_OK) |-> out_page_r == '0)
    else $error("nonzero page on failed request");

  // The table is only written while a request is in progress
  a_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r != S_IDLE) && (state_r != S_OUT))
    else $error("table write outside a request");

  // A completed request leaves the result register full
  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT) && (!out_valid_r || out_ready) |=> out_valid_r)
    else $error("result beat lost");

endmodule
`default_nettype wire
